// ===== rtl/cce_pkg.sv =====
package cce_pkg;

    localparam int ADDR_BITS_DEF = 24;
    localparam int RAM_SIZE_W    = 25;
    localparam int DIV_W         = RAM_SIZE_W;

    localparam logic [RAM_SIZE_W-1:0] RAM_SIZE_RST = 25'd2097152;

    localparam logic [7:0] TYPE_WRITE8   = 8'h30;
    localparam logic [7:0] TYPE_WRITE16  = 8'h80;
    localparam logic [7:0] TYPE_SLIDE    = 8'h50;
    localparam logic [7:0] TYPE_EQ16     = 8'hD0;
    localparam logic [7:0] TYPE_NE16     = 8'hD1;
    localparam logic [7:0] TYPE_LT16     = 8'hD2;
    localparam logic [7:0] TYPE_GT16     = 8'hD3;
    localparam logic [7:0] TYPE_EQ8      = 8'hE0;
    localparam logic [7:0] TYPE_NE8      = 8'hE1;
    localparam logic [7:0] TYPE_LT8      = 8'hE2;
    localparam logic [7:0] TYPE_GT8      = 8'hE3;
    localparam logic [7:0] TYPE_BOUNDARY = 8'hFF;

    typedef struct packed {
        logic [31:0] code_word;
        logic [15:0] value_word;
        logic [7:0]  mem_byte;
        logic [15:0] mem_halfword;
    } t_in_item;

    typedef struct packed {
        logic [23:0] write_address;
        logic [15:0] write_value;
        logic        write_wide;
        logic [7:0]  address_step;
        logic [15:0] value_step;
        logic [7:0]  write_count;
    } t_out_item;

    typedef struct packed {
        logic              start;
        logic [DIV_W-1:0]  dividend;
        logic [7:0]        divisor;
    } t_div_req;

endpackage

// ===== rtl/cce_div.sv =====
module cce_div
    import cce_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_div_req         i_req,
    output logic             o_done,
    output logic [DIV_W-1:0] o_quotient
);

    localparam int CNT_W = $clog2(DIV_W);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DIV_W-1:0] r_quo;
    logic [7:0]       r_rem;
    logic [7:0]       r_div;

    logic [8:0] w_trial;
    logic       w_ge;
    logic [8:0] w_rem_next;

    // one quotient bit per cycle, restoring
    assign w_trial    = {r_rem, r_quo[DIV_W-1]};
    assign w_ge       = w_trial >= {1'b0, r_div};
    assign w_rem_next = w_ge ? (w_trial - {1'b0, r_div}) : w_trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_quo  <= i_req.dividend;
                r_rem  <= '0;
                r_div  <= i_req.divisor;
            end else if (r_busy) begin
                r_rem <= w_rem_next[7:0];
                r_quo <= {r_quo[DIV_W-2:0], w_ge};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DIV_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// ===== rtl/cheat_code_engine.sv =====
// Channel  | Direction | Handshake               | Payload
// ---------+-----------+-------------------------+-----------------------
// input    | in        | i_in_valid / o_in_ready | i_in_data  (t_in_item)
// result   | out       | o_out_valid/ i_out_ready| o_out_data (t_out_item)
// config   | in        | i_cfg_we, no wait       | i_cfg_data (ram_size)
//
// One code per transfer; ready is low until its result, if any, is taken.
// A write that fits under an armed slide with nonzero address step runs
// the serial divider (one quotient bit per cycle, 25 bits).
// Synchronous active-low reset clears skip, slide and sets ram_size.
// A stalled result holds the block until it is taken.
module cheat_code_engine
    import cce_pkg::*;
#(
    parameter int ADDR_BITS = ADDR_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [RAM_SIZE_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_item              i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_item             o_out_data
);

    localparam logic [23:0] ADDR_MASK = 24'((25'd1 << ADDR_BITS) - 25'd1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_OUT
    } t_state;

    t_state                r_state;
    logic [RAM_SIZE_W-1:0] r_ram_size;
    logic                  r_skip;
    logic [7:0]            r_slide_rep;
    logic [7:0]            r_slide_astep;
    logic [15:0]           r_slide_vstep;
    logic [7:0]            r_repeats;
    t_out_item             r_out;

    logic                  w_accept;
    logic [7:0]            w_type;
    logic [23:0]           w_addr;
    logic                  w_wide;
    logic [25:0]           w_end;
    logic                  w_fits;
    logic                  w_sl;
    logic                  w_is_write;
    logic [15:0]           w_vmask;
    logic [7:0]            w_v8;
    t_div_req              w_div_req;
    logic                  w_div_done;
    logic [DIV_W-1:0]      w_quo;

    assign w_accept   = i_in_valid && o_in_ready;
    assign w_type     = i_in_data.code_word[31:24];
    assign w_addr     = i_in_data.code_word[23:0] & ADDR_MASK;
    assign w_wide     = (w_type == TYPE_WRITE16);
    assign w_end      = {2'b00, w_addr} + (w_wide ? 26'd2 : 26'd1);
    assign w_fits     = w_end <= {1'b0, r_ram_size};
    assign w_sl       = (r_slide_rep != 8'd0);
    assign w_is_write = (w_type == TYPE_WRITE8) || (w_type == TYPE_WRITE16);
    assign w_vmask    = w_wide ? 16'hFFFF : 16'h00FF;
    assign w_v8       = i_in_data.value_word[7:0];

    // span left after the first write, divided by the step gives extra writes
    assign w_div_req.start    = w_accept && !r_skip && w_is_write && w_fits && w_sl &&
                                (r_slide_astep != 8'd0);
    assign w_div_req.dividend = r_ram_size - w_end[RAM_SIZE_W-1:0];
    assign w_div_req.divisor  = r_slide_astep;

    cce_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (w_div_req),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_ram_size    <= RAM_SIZE_RST;
            r_skip        <= 1'b0;
            r_slide_rep   <= '0;
            r_slide_astep <= '0;
            r_slide_vstep <= '0;
        end else begin
            if (i_cfg_we) begin
                r_ram_size <= i_cfg_data;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        if (w_type == TYPE_BOUNDARY) begin
                            r_skip      <= 1'b0;
                            r_slide_rep <= '0;
                        end else if (r_skip) begin
                            // drop the line
                            r_skip <= 1'b0;
                        end else begin
                            case (w_type)
                                TYPE_SLIDE: begin
                                    r_slide_rep   <= i_in_data.code_word[15:8];
                                    r_slide_astep <= i_in_data.code_word[7:0];
                                    r_slide_vstep <= i_in_data.value_word;
                                end
                                TYPE_WRITE8, TYPE_WRITE16: begin
                                    r_slide_rep <= '0;
                                    r_repeats   <= r_slide_rep;
                                    r_out.write_address <= w_addr;
                                    r_out.write_value   <= i_in_data.value_word & w_vmask;
                                    r_out.write_wide    <= w_wide;
                                    r_out.address_step  <= w_sl ? r_slide_astep : 8'd0;
                                    r_out.value_step    <= w_sl ? (r_slide_vstep & w_vmask)
                                                                : 16'd0;
                                    r_out.write_count   <= w_sl ? r_slide_rep : 8'd1;
                                    if (w_fits) begin
                                        r_state <= w_div_req.start ? S_DIV : S_OUT;
                                    end
                                end
                                TYPE_EQ16: r_skip <= (i_in_data.mem_halfword !=
                                                      i_in_data.value_word);
                                TYPE_NE16: r_skip <= (i_in_data.mem_halfword ==
                                                      i_in_data.value_word);
                                TYPE_LT16: r_skip <= !(i_in_data.mem_halfword <
                                                       i_in_data.value_word);
                                TYPE_GT16: r_skip <= !(i_in_data.mem_halfword >
                                                       i_in_data.value_word);
                                TYPE_EQ8:  r_skip <= (i_in_data.mem_byte != w_v8);
                                TYPE_NE8:  r_skip <= (i_in_data.mem_byte == w_v8);
                                TYPE_LT8:  r_skip <= !(i_in_data.mem_byte < w_v8);
                                TYPE_GT8:  r_skip <= !(i_in_data.mem_byte > w_v8);
                                default: begin
                                end
                            endcase
                        end
                    end
                end
                S_DIV: begin
                    if (w_div_done) begin
                        // clip to quotient + 1 when fewer than the repeats fit
                        if (w_quo < {{(DIV_W-8){1'b0}}, r_repeats}) begin
                            r_out.write_count <= w_quo[7:0] + 8'd1;
                        end else begin
                            r_out.write_count <= r_repeats;
                        end
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (i_out_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);
    assign o_out_data  = r_out;

    a_out_blocks_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !o_in_ready)
        else $error("input ready while a result is pending");

    a_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.write_count != 8'd0))
        else $error("result with zero write count");

    a_first_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (({2'b00, o_out_data.write_address} +
                          (o_out_data.write_wide ? 26'd2 : 26'd1)) <= {1'b0, r_ram_size}))
        else $error("result first write past ram size");

    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == S_DIV))
        else $error("divider finished outside the divide state");

    a_div_start_leads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_req.start |=> (r_state == S_DIV))
        else $error("divider started without entering the divide state");

endmodule

// ===== tb/sv/tb.sv =====
module tb
    import cce_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum {SINK_FREE, SINK_COIN, SINK_PATTERN, SINK_RARE} t_sink_mode;

    localparam int HOLD_CYCLES   = 500;
    localparam int SETTLE_CYCLES = 64;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [RAM_SIZE_W-1:0] i_cfg_data = '0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    t_in_item              i_in_data = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    t_out_item             o_out_data;

    cheat_code_engine u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // interpreter state as the block should hold it
    logic [RAM_SIZE_W-1:0] ram_bytes = RAM_SIZE_RST;
    bit                    skip_armed = 1'b0;
    logic [7:0]            slide_reps = '0;
    logic [7:0]            slide_astep = '0;
    logic [15:0]           slide_vstep = '0;

    t_in_item    pending_codes[$];
    t_out_item   expected_bursts[$];
    int unsigned codes_queued = 0;
    int unsigned codes_accepted = 0;
    int unsigned fail_count = 0;
    bit          in_xfer = 1'b0;

    int unsigned hold_reqs = 0;
    int unsigned hold_served = 0;
    int unsigned sink_hold = 0;
    int unsigned sink_left = 0;
    int unsigned sink_tick = 0;
    t_sink_mode  sink_mode = SINK_FREE;
    int unsigned src_gap = 0;
    int unsigned src_burst = 1;

    function automatic bit interpret_code(input t_in_item c, output t_out_item burst);
        logic [7:0]  kind;
        logic [23:0] addr;
        logic [25:0] width;
        logic [15:0] vmask;
        logic [7:0]  reps;
        logic [7:0]  astep;
        logic [15:0] vstep;
        logic [25:0] fit;
        kind = c.code_word[31:24];
        addr = c.code_word[23:0];
        burst = '0;
        if (kind == TYPE_BOUNDARY) begin
            skip_armed = 1'b0;
            slide_reps = '0;
            return 1'b0;
        end
        if (skip_armed) begin
            skip_armed = 1'b0;
            return 1'b0;
        end
        case (kind)
            TYPE_SLIDE: begin
                slide_reps  = c.code_word[15:8];
                slide_astep = c.code_word[7:0];
                slide_vstep = c.value_word;
            end
            TYPE_WRITE8, TYPE_WRITE16: begin
                width = (kind == TYPE_WRITE8) ? 26'd1 : 26'd2;
                vmask = (kind == TYPE_WRITE8) ? 16'h00FF : 16'hFFFF;
                reps  = (slide_reps != 0) ? slide_reps : 8'd1;
                astep = (slide_reps != 0) ? slide_astep : 8'd0;
                vstep = (slide_reps != 0) ? slide_vstep : 16'd0;
                // any executed write uses up the slide, even a refused one
                slide_reps = '0;
                if (26'(addr) + width > 26'(ram_bytes))
                    return 1'b0;
                burst.write_address = addr;
                burst.write_value   = c.value_word & vmask;
                burst.write_wide    = (kind == TYPE_WRITE16);
                burst.address_step  = astep;
                burst.value_step    = vstep & vmask;
                burst.write_count   = reps;
                if (astep != 0) begin
                    fit = (26'(ram_bytes) - width - 26'(addr)) / 26'(astep) + 26'd1;
                    if (fit < 26'(reps))
                        burst.write_count = fit[7:0];
                end
                return 1'b1;
            end
            TYPE_EQ16: skip_armed = (c.mem_halfword != c.value_word);
            TYPE_NE16: skip_armed = (c.mem_halfword == c.value_word);
            TYPE_LT16: skip_armed = !(c.mem_halfword < c.value_word);
            TYPE_GT16: skip_armed = !(c.mem_halfword > c.value_word);
            TYPE_EQ8:  skip_armed = (c.mem_byte != c.value_word[7:0]);
            TYPE_NE8:  skip_armed = (c.mem_byte == c.value_word[7:0]);
            TYPE_LT8:  skip_armed = !(c.mem_byte < c.value_word[7:0]);
            TYPE_GT8:  skip_armed = !(c.mem_byte > c.value_word[7:0]);
            default: ;
        endcase
        return 1'b0;
    endfunction

    function automatic bit known_kind(logic [7:0] k);
        case (k)
            TYPE_WRITE8, TYPE_WRITE16, TYPE_SLIDE, TYPE_BOUNDARY,
            TYPE_EQ16, TYPE_NE16, TYPE_LT16, TYPE_GT16,
            TYPE_EQ8, TYPE_NE8, TYPE_LT8, TYPE_GT8: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic string fmt_burst(t_out_item b);
        return $sformatf("addr=%06h val=%04h wide=%0b astep=%02h vstep=%04h count=%0d",
                         b.write_address, b.write_value, b.write_wide,
                         b.address_step, b.value_step, b.write_count);
    endfunction

    task automatic note_failure(string msg);
        fail_count++;
        if (fail_count <= 10)
            $display("%s", msg);
    endtask

    task automatic put(logic [7:0] kind, logic [23:0] field, logic [15:0] val,
                       logic [7:0] mb, logic [15:0] mh);
        t_in_item c;
        c.code_word    = {kind, field};
        c.value_word   = val;
        c.mem_byte     = mb;
        c.mem_halfword = mh;
        pending_codes.push_back(c);
        codes_queued++;
    endtask

    // bias addresses toward the top of RAM so clipping and refusal show up
    function automatic logic [23:0] pick_addr();
        int unsigned r;
        int unsigned top;
        r = $urandom_range(0, 9);
        top = 32'(ram_bytes);
        if (r < 4 && top != 0)
            return 24'(top - $urandom_range(0, (top > 600) ? 600 : top));
        else if (r < 7 && top != 0)
            return 24'($urandom_range(0, top - 1));
        return 24'($urandom);
    endfunction

    task automatic put_write();
        put($urandom_range(0, 1) ? TYPE_WRITE16 : TYPE_WRITE8, pick_addr(),
            16'($urandom), 8'($urandom), 16'($urandom));
    endtask

    task automatic put_slide();
        logic [7:0] reps;
        logic [7:0] astep;
        case ($urandom_range(0, 3))
            0: reps = 8'd0;
            1: reps = 8'($urandom_range(1, 4));
            2: reps = 8'd255;
            default: reps = 8'($urandom);
        endcase
        astep = ($urandom_range(0, 4) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
        put(TYPE_SLIDE, {8'($urandom), reps, astep}, 16'($urandom),
            8'($urandom), 16'($urandom));
    endtask

    task automatic queue_random_codes(int unsigned n);
        int unsigned goal;
        int unsigned r;
        logic [7:0]  kind;
        logic [15:0] val;
        logic [7:0]  mb;
        logic [15:0] mh;
        logic [31:0] code;
        goal = codes_queued + n;
        while (codes_queued < goal) begin
            r = $urandom_range(0, 99);
            if (r < 10) begin
                put(TYPE_BOUNDARY, 24'($urandom), 16'($urandom), 8'($urandom), 16'($urandom));
            end else if (r < 38) begin
                put_write();
            end else if (r < 62) begin
                put_slide();
                put_write();
            end else if (r < 84) begin
                case ($urandom_range(0, 7))
                    0: kind = TYPE_EQ16;
                    1: kind = TYPE_NE16;
                    2: kind = TYPE_LT16;
                    3: kind = TYPE_GT16;
                    4: kind = TYPE_EQ8;
                    5: kind = TYPE_NE8;
                    6: kind = TYPE_LT8;
                    default: kind = TYPE_GT8;
                endcase
                val = 16'($urandom);
                mb = 8'($urandom);
                mh = 16'($urandom);
                // make equality common so both outcomes of every compare occur
                case ($urandom_range(0, 2))
                    0: begin
                        mh = val;
                        mb = val[7:0];
                    end
                    1: begin
                        mh = val ^ 16'h0001;
                        mb = val[7:0] ^ 8'h01;
                    end
                    default: ;
                endcase
                put(kind, 24'($urandom), val, mb, mh);
                if ($urandom_range(0, 1)) begin
                    put_write();
                end else begin
                    put_slide();
                    put_write();
                end
            end else if (r < 92) begin
                do kind = 8'($urandom); while (known_kind(kind));
                put(kind, 24'($urandom), 16'($urandom), 8'($urandom), 16'($urandom));
            end else begin
                code = $urandom;
                put(code[31:24], code[23:0], 16'($urandom), 8'($urandom), 16'($urandom));
            end
        end
    endtask

    task automatic queue_directed();
        put(TYPE_WRITE8,  24'h000000, 16'hFFFF, 8'h00, 16'h0000);
        put(TYPE_WRITE16, 24'h1FFFFE, 16'hABCD, 8'h00, 16'h0000);
        put(TYPE_WRITE16, 24'h1FFFFF, 16'h1111, 8'h00, 16'h0000);
        // slide clipped at the top of RAM
        put(TYPE_SLIDE,   {8'h00, 8'd10, 8'd4}, 16'h0101, 8'h00, 16'h0000);
        put(TYPE_WRITE16, 24'h1FFFF0, 16'h1234, 8'h00, 16'h0000);
        // zero repeat leaves a plain write
        put(TYPE_SLIDE,   {8'h00, 8'd0, 8'd7}, 16'h5555, 8'h00, 16'h0000);
        put(TYPE_WRITE8,  24'h000100, 16'h00AA, 8'h00, 16'h0000);
        // zero address step at the last byte
        put(TYPE_SLIDE,   {8'h00, 8'd255, 8'd0}, 16'hFFFF, 8'h00, 16'h0000);
        put(TYPE_WRITE8,  24'h1FFFFF, 16'h007F, 8'h00, 16'h0000);
        // refused write still consumes the slide
        put(TYPE_SLIDE,   {8'h00, 8'd3, 8'd1}, 16'h0002, 8'h00, 16'h0000);
        put(TYPE_WRITE16, 24'h1FFFFF, 16'h2222, 8'h00, 16'h0000);
        put(TYPE_EQ16,    24'h000010, 16'h8000, 8'h00, 16'h8000);
        put(TYPE_WRITE8,  24'h000010, 16'h0033, 8'h00, 16'h0000);
        // failed compare drops the slide that follows
        put(TYPE_NE16,    24'h000020, 16'h4444, 8'h00, 16'h4444);
        put(TYPE_SLIDE,   {8'h00, 8'd5, 8'd2}, 16'h0001, 8'h00, 16'h0000);
        put(TYPE_WRITE8,  24'h000020, 16'h0044, 8'h00, 16'h0000);
        put(TYPE_LT8,     24'h000030, 16'h0000, 8'hFF, 16'h0000);
        put(8'h00,        24'h000030, 16'h0000, 8'h00, 16'h0000);
        put(TYPE_GT8,     24'h000030, 16'h12FE, 8'hFF, 16'h0000);
        put(TYPE_LT16,    24'h000030, 16'hFFFF, 8'h00, 16'h0000);
        put(TYPE_GT16,    24'h000030, 16'h0000, 8'h00, 16'h0000);
        put(TYPE_BOUNDARY, 24'h000000, 16'h0000, 8'h00, 16'h0000);
        put(TYPE_WRITE16, 24'h000002, 16'h5A5A, 8'h00, 16'h0000);
        // unknown code keeps the latched slide
        put(TYPE_SLIDE,   {8'h00, 8'd2, 8'd8}, 16'h0010, 8'h00, 16'h0000);
        put(8'hC5,        24'h000040, 16'h0000, 8'h00, 16'h0000);
        put(TYPE_WRITE8,  24'h000040, 16'h0001, 8'h00, 16'h0000);
        put(TYPE_NE8,     24'h000050, 16'h0033, 8'h33, 16'h0000);
        put(TYPE_EQ8,     24'h000050, 16'h0033, 8'h33, 16'h0000);
        put(TYPE_WRITE8,  24'h000050, 16'h0099, 8'h00, 16'h0000);
    endtask

    task automatic wait_drain();
        do @(negedge i_clk);
        while (codes_accepted != codes_queued || expected_bursts.size() != 0);
    endtask

    task automatic settle();
        wait_drain();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic set_ram_size(logic [RAM_SIZE_W-1:0] v);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        ram_bytes = v;
    endtask

    // sender: bursts of transfers separated by random gaps
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || in_xfer) begin
            if (src_gap != 0) begin
                src_gap--;
                i_in_valid <= 1'b0;
            end else if (pending_codes.size() != 0) begin
                i_in_valid <= 1'b1;
                i_in_data  <= pending_codes.pop_front();
                if (src_burst > 1) begin
                    src_burst--;
                end else begin
                    src_burst = $urandom_range(1, 24);
                    src_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // receiver: long holds on request, otherwise a changing stall pattern
    always @(negedge i_clk) begin
        if (sink_hold != 0) begin
            sink_hold--;
            i_out_ready <= 1'b0;
        end else if (hold_served != hold_reqs) begin
            hold_served++;
            sink_hold = HOLD_CYCLES;
            i_out_ready <= 1'b0;
        end else begin
            if (sink_left == 0) begin
                sink_mode = t_sink_mode'($urandom_range(0, 3));
                sink_left = $urandom_range(40, 300);
            end
            sink_left--;
            sink_tick++;
            case (sink_mode)
                SINK_FREE:    i_out_ready <= 1'b1;
                SINK_COIN:    i_out_ready <= 1'($urandom_range(0, 1));
                SINK_PATTERN: i_out_ready <= (sink_tick % 7) >= 3;
                default:      i_out_ready <= ($urandom_range(0, 9) != 0);
            endcase
        end
    end

    always @(posedge i_clk) begin
        t_out_item want;
        in_xfer = i_rst_n && i_in_valid && o_in_ready;
        if (in_xfer) begin
            codes_accepted++;
            if (interpret_code(i_in_data, want))
                expected_bursts.push_back(want);
        end
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_bursts.size() == 0) begin
                note_failure($sformatf("unexpected burst %s", fmt_burst(o_out_data)));
            end else begin
                want = expected_bursts.pop_front();
                if (o_out_data !== want)
                    note_failure($sformatf("burst mismatch: expected %s, got %s",
                                           fmt_burst(want), fmt_burst(o_out_data)));
            end
        end
    end

    initial begin
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        queue_directed();
        queue_random_codes(200);
        // hold the result side while codes keep coming
        hold_reqs++;
        queue_random_codes(100);
        // queue no more codes until every code is taken and every burst is back
        wait_drain();
        queue_random_codes(80);
        settle();

        set_ram_size('0);
        queue_random_codes(80);
        settle();

        set_ram_size(25'h1000000);
        queue_random_codes(250);
        hold_reqs++;
        settle();

        set_ram_size(25'd1);
        queue_random_codes(80);
        settle();

        set_ram_size('1);
        queue_random_codes(220);
        settle();

        set_ram_size(25'($urandom_range(2, 8192)));
        queue_random_codes(250);
        settle();

        set_ram_size(RAM_SIZE_RST);
        queue_random_codes(170);
        settle();

        if (expected_bursts.size() != 0)
            note_failure("bursts still expected at end of run");
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        #4_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
